// ===== rtl/frwl_pkg.sv =====
// Shared types and constants for the fair reader-writer lock manager.
// Holds request and result formats and queue sizes; depends on nothing.
`default_nettype none

package frwl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_CLIENTS = 64;
    localparam int REQ_Q_DEPTH = 2;

    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int COUNT_W  = $clog2(MAX_CLIENTS + 1);
    localparam int RQ_AW    = $clog2(REQ_Q_DEPTH);
    localparam int RQ_CNT_W = $clog2(REQ_Q_DEPTH + 1);

    localparam int CMD_W    = 2;
    localparam int CLIENT_W = 6;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_READ_LOCK    = 2'd0,
        CMD_WRITE_LOCK   = 2'd1,
        CMD_READ_UNLOCK  = 2'd2,
        CMD_WRITE_UNLOCK = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_GRANTED  = 2'd0,
        KIND_QUEUED   = 2'd1,
        KIND_RELEASED = 2'd2,
        KIND_ERROR    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_QUEUE_FULL = 2'd1,
        ERR_NO_HOLDER  = 2'd2
    } t_err;

    typedef struct packed {
        t_cmd                cmd;
        logic [CLIENT_W-1:0] requester;
        logic                is_writer;
    } t_req;

    typedef struct packed {
        t_kind               kind;
        logic [CLIENT_W-1:0] client;
        logic                as_writer;
        t_err                error_code;
        logic [COUNT_W-1:0]  active_readers;
        logic                last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/frwl_front.sv =====
// Request front end: registers incoming words and classifies the command.
// Feeds the request queue; uses frwl_pkg.
`default_nettype none

module frwl_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [frwl_pkg::CMD_W-1:0]    i_s_cmd,
    input  wire logic [frwl_pkg::CLIENT_W-1:0] i_s_requester,
    output logic                               o_q_valid,
    input  wire logic                          i_q_ready,
    output frwl_pkg::t_req                     o_q_req
);
    import frwl_pkg::*;

    logic r_valid;
    t_req r_req;
    t_req n_req;

    always_comb begin
        n_req.cmd       = t_cmd'(i_s_cmd);
        n_req.requester = i_s_requester;
        n_req.is_writer = (n_req.cmd == CMD_WRITE_LOCK) || (n_req.cmd == CMD_WRITE_UNLOCK);
    end

    assign o_s_tready = !r_valid || i_q_ready;
    assign o_q_valid  = r_valid;
    assign o_q_req    = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_req <= n_req;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/frwl_req_queue.sv =====
// Short queue of classified requests between the front end and the lock engine.
// Uses frwl_pkg.
`default_nettype none

module frwl_req_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire frwl_pkg::t_req i_push_req,
    output logic                o_pop_valid,
    input  wire logic           i_pop,
    output frwl_pkg::t_req      o_pop_req
);
    import frwl_pkg::*;

    t_req                r_mem [REQ_Q_DEPTH];
    logic [RQ_AW-1:0]    r_wr;
    logic [RQ_AW-1:0]    r_rd;
    logic [RQ_CNT_W-1:0] r_cnt;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_cnt != RQ_CNT_W'(REQ_Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_req    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == RQ_AW'(REQ_Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == RQ_AW'(REQ_Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_req;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/frwl_engine.sv =====
// Lock engine: holds the lock state and waiter queue, and produces results.
// A run of woken readers is granted one per cycle while the output is free. Uses frwl_pkg.
`default_nettype none

module frwl_engine (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    input  wire frwl_pkg::t_req i_req,
    output logic                o_req_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output frwl_pkg::t_result   o_result
);
    import frwl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WAKE = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic                r_busy, n_busy;
    logic [COUNT_W-1:0]  r_rc, n_rc;
    logic [QUEUE_AW-1:0] r_head, n_head;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [CLIENT_W-1:0] r_wait_client [QUEUE_DEPTH];
    logic                r_wait_wr [QUEUE_DEPTH];
    logic                r_out_valid;
    t_result             r_out;

    t_result             res;
    logic                out_free;
    logic                fire;
    logic                push;
    logic                pop_req;
    logic                wake_go;
    logic [COUNT_W-1:0]  wake_base;
    logic [QUEUE_AW-1:0] tail;
    logic [QUEUE_AW-1:0] next_head;
    logic                next_is_reader;
    logic                q_full;
    logic [COUNT_W-1:0]  rc_inc;

    assign out_free       = !r_out_valid || i_out_ready;
    assign tail           = r_head + r_fill[QUEUE_AW-1:0];
    assign next_head      = r_head + 1'b1;
    assign next_is_reader = (r_fill > FILL_W'(1)) && !r_wait_wr[next_head];
    assign q_full         = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign rc_inc         = (r_rc < COUNT_W'(MAX_CLIENTS)) ? r_rc + 1'b1 : r_rc;

    always_comb begin
        n_state   = r_state;
        n_busy    = r_busy;
        n_rc      = r_rc;
        n_head    = r_head;
        n_fill    = r_fill;
        push      = 1'b0;
        pop_req   = 1'b0;
        wake_go   = 1'b0;
        wake_base = '0;
        fire      = 1'b0;
        res.kind           = KIND_GRANTED;
        res.client         = i_req.requester;
        res.as_writer      = i_req.is_writer;
        res.error_code     = ERR_NONE;
        res.active_readers = r_rc;
        res.last           = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid && out_free) begin
                    pop_req = 1'b1;
                    fire    = 1'b1;
                    unique case (i_req.cmd)
                        CMD_READ_LOCK: begin
                            if (r_busy) begin
                                if (q_full) begin
                                    res.kind       = KIND_ERROR;
                                    res.error_code = ERR_QUEUE_FULL;
                                end else begin
                                    push     = 1'b1;
                                    res.kind = KIND_QUEUED;
                                end
                            end else begin
                                n_rc               = rc_inc;
                                res.active_readers = rc_inc;
                            end
                        end
                        CMD_WRITE_LOCK: begin
                            if (r_busy || (r_rc != '0)) begin
                                if (q_full) begin
                                    res.kind       = KIND_ERROR;
                                    res.error_code = ERR_QUEUE_FULL;
                                end else begin
                                    n_busy   = 1'b1;
                                    push     = 1'b1;
                                    res.kind = KIND_QUEUED;
                                end
                            end else begin
                                n_busy = 1'b1;
                            end
                        end
                        CMD_READ_UNLOCK: begin
                            if (r_rc == '0) begin
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_NO_HOLDER;
                            end else if ((r_rc == COUNT_W'(1)) && (r_fill != '0)) begin
                                wake_go = 1'b1;
                            end else begin
                                n_rc               = r_rc - 1'b1;
                                res.kind           = KIND_RELEASED;
                                res.active_readers = r_rc - 1'b1;
                            end
                        end
                        CMD_WRITE_UNLOCK: begin
                            if (!r_busy || (r_rc != '0)) begin
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_NO_HOLDER;
                            end else if (r_fill == '0) begin
                                n_busy   = 1'b0;
                                res.kind = KIND_RELEASED;
                            end else begin
                                wake_go = 1'b1;
                            end
                        end
                        default: begin
                            res.kind = KIND_ERROR;
                        end
                    endcase
                end
            end
            ST_WAKE: begin
                if (out_free) begin
                    fire      = 1'b1;
                    wake_go   = 1'b1;
                    wake_base = r_rc;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (push) begin
            n_fill = r_fill + 1'b1;
        end

        if (wake_go) begin
            n_head         = next_head;
            n_fill         = r_fill - 1'b1;
            res.kind       = KIND_GRANTED;
            res.client     = r_wait_client[r_head];
            res.error_code = ERR_NONE;
            if (r_wait_wr[r_head]) begin
                n_busy        = 1'b1;
                n_rc          = wake_base;
                res.as_writer = 1'b1;
                res.last      = 1'b1;
                n_state       = ST_IDLE;
            end else begin
                n_rc = (wake_base < COUNT_W'(MAX_CLIENTS)) ? wake_base + 1'b1 : wake_base;
                res.as_writer = 1'b0;
                if (next_is_reader) begin
                    res.last = 1'b0;
                    n_state  = ST_WAKE;
                end else begin
                    res.last = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_fill == FILL_W'(1)) begin
                        n_busy = 1'b0;
                    end
                end
            end
            res.active_readers = n_rc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_busy      <= 1'b0;
            r_rc        <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_rc    <= n_rc;
            r_head  <= n_head;
            r_fill  <= n_fill;
            if (out_free) begin
                r_out_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_wait_client[tail] <= i_req.requester;
            r_wait_wr[tail]     <= i_req.is_writer;
        end
        if (out_free && fire) begin
            r_out <= res;
        end
    end

    assign o_req_pop   = pop_req;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

// ===== rtl/fair_reader_writer_lock.sv =====
// Top level of the fair reader-writer lock manager.
// Instantiates frwl_front, frwl_req_queue and frwl_engine; uses frwl_pkg.
//
//   Channel   Direction  tdata                                          tuser  tlast
//   s_axis    in         requester[5:0]                                 cmd    -
//   m_axis    out        client[5:0] as_writer[6] error_code[8:7]
//                        active_readers[15:9]                           kind   last
//
// A request gives one result word; an unlock that wakes a run of n readers gives n
// words, as the engine grants one reader per cycle while the output is not stalled.
// Requests pass the front-end register and request queue; results are registered.
// Reset is synchronous; the lock is free and the waiter queue empty afterward.
// A stalled output holds the engine; the request queue keeps accepting until full.
`default_nettype none

module fair_reader_writer_lock (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [frwl_pkg::S_DATA_W-1:0] i_s_axis_tdata,  // requester
    input  wire logic [frwl_pkg::CMD_W-1:0]    i_s_axis_tuser,  // cmd
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // client, as_writer, error_code, active_readers
    output logic [frwl_pkg::M_DATA_W-1:0]      o_m_axis_tdata,
    output logic [1:0]                         o_m_axis_tuser,  // kind
    output logic                               o_m_axis_tlast
);
    import frwl_pkg::*;

    logic    fq_valid;
    logic    fq_ready;
    t_req    fq_req;
    logic    qe_valid;
    logic    qe_pop;
    t_req    qe_req;
    t_result result;

    frwl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_axis_tvalid),
        .o_s_tready    (o_s_axis_tready),
        .i_s_cmd       (i_s_axis_tuser),
        .i_s_requester (i_s_axis_tdata[CLIENT_W-1:0]),
        .o_q_valid     (fq_valid),
        .i_q_ready     (fq_ready),
        .o_q_req       (fq_req)
    );

    frwl_req_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_req   (fq_req),
        .o_pop_valid  (qe_valid),
        .i_pop        (qe_pop),
        .o_pop_req    (qe_req)
    );

    frwl_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (qe_valid),
        .i_req       (qe_req),
        .o_req_pop   (qe_pop),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_result    (result)
    );

    assign o_m_axis_tdata = {result.active_readers, result.error_code,
                             result.as_writer, result.client};
    assign o_m_axis_tuser = result.kind;
    assign o_m_axis_tlast = result.last;

endmodule

`default_nettype wire

// ===== rtl/frwl_checker.sv =====
// Port-level checker for the fair reader-writer lock manager, with its bind.
// Watches the top-level ports only; uses frwl_pkg.
`default_nettype none

module frwl_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_m_axis_tvalid,
    input wire logic                          i_m_axis_tready,
    input wire logic [frwl_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    input wire logic [1:0]                    o_m_axis_tuser,
    input wire logic                          o_m_axis_tlast
);
    import frwl_pkg::*;

    logic [1:0]         err;
    logic [COUNT_W-1:0] readers;
    logic               wr;

    assign wr      = o_m_axis_tdata[CLIENT_W];
    assign err     = o_m_axis_tdata[CLIENT_W+2:CLIENT_W+1];
    assign readers = o_m_axis_tdata[M_DATA_W-1:CLIENT_W+3];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
            && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tuser == KIND_ERROR) == (err != ERR_NONE)))
        else $error("error code does not match result kind");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != KIND_GRANTED) |-> o_m_axis_tlast)
        else $error("non-grant result not marked last");

    a_writer_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_GRANTED) && wr
            |-> (readers == '0) && o_m_axis_tlast)
        else $error("write grant with readers active or in a run");

    a_readers_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (readers <= COUNT_W'(MAX_CLIENTS)))
        else $error("reader count above limit");

endmodule

bind fair_reader_writer_lock frwl_checker u_frwl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

// ===== bench/frwl_status_checker.sv =====
// Checker for the fair reader-writer lock manager: watches both stream channels,
// predicts the status words of every accepted request and compares them in order.
// Depends on frwl_pkg for request and status types and for the queue sizes.
module frwl_status_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    input  wire logic [frwl_pkg::S_DATA_W-1:0]   i_s_tdata,  // requester
    input  wire logic [frwl_pkg::CMD_W-1:0]      i_s_tuser,  // cmd
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    // client, as_writer, error_code, active_readers
    input  wire logic [frwl_pkg::M_DATA_W-1:0]   i_m_tdata,
    input  wire logic [1:0]                      i_m_tuser,  // kind
    input  wire logic                            i_m_tlast,
    output int                                   o_mismatches,
    output int                                   o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import frwl_pkg::*;

    logic                lock_busy;
    logic [COUNT_W-1:0]  reader_cnt;
    int                  wait_head;
    int                  wait_fill;
    logic [CLIENT_W-1:0] wait_id [QUEUE_DEPTH];
    logic                wait_wr [QUEUE_DEPTH];
    t_result             status_q [$];

    task automatic report_mismatch(string msg);
        $display("%0t ns: status mismatch: %s", $time, msg);
        o_mismatches++;
    endtask

    task automatic post_status(t_kind k, logic [CLIENT_W-1:0] who, logic wr, t_err err);
        t_result r;
        r.kind           = k;
        r.client         = who;
        r.as_writer      = wr;
        r.error_code     = err;
        r.active_readers = reader_cnt;
        r.last           = 1'b0;
        status_q.push_back(r);
    endtask

    task automatic count_reader();
        if (reader_cnt < COUNT_W'(MAX_CLIENTS)) begin
            reader_cnt++;
        end
    endtask

    task automatic drop_head();
        wait_head = (wait_head + 1) % QUEUE_DEPTH;
        wait_fill--;
    endtask

    task automatic enqueue_waiter(logic [CLIENT_W-1:0] who, logic wr);
        int slot;
        slot          = (wait_head + wait_fill) % QUEUE_DEPTH;
        wait_id[slot] = who;
        wait_wr[slot] = wr;
        wait_fill++;
    endtask

    task automatic wake_waiters();
        logic [CLIENT_W-1:0] who;
        if (wait_wr[wait_head]) begin
            who = wait_id[wait_head];
            drop_head();
            lock_busy = 1'b1;
            post_status(KIND_GRANTED, who, 1'b1, ERR_NONE);
        end else begin
            while (wait_fill > 0 && !wait_wr[wait_head]) begin
                who = wait_id[wait_head];
                drop_head();
                count_reader();
                post_status(KIND_GRANTED, who, 1'b0, ERR_NONE);
            end
            if (wait_fill == 0) begin
                lock_busy = 1'b0;
            end
        end
    endtask

    task automatic predict_request(t_cmd cmd, logic [CLIENT_W-1:0] who);
        logic    wr;
        t_result tail;
        wr = (cmd == CMD_WRITE_LOCK || cmd == CMD_WRITE_UNLOCK);
        case (cmd)
            CMD_READ_LOCK: begin
                if (!lock_busy) begin
                    count_reader();
                    post_status(KIND_GRANTED, who, 1'b0, ERR_NONE);
                end else if (wait_fill >= QUEUE_DEPTH) begin
                    post_status(KIND_ERROR, who, wr, ERR_QUEUE_FULL);
                end else begin
                    enqueue_waiter(who, 1'b0);
                    post_status(KIND_QUEUED, who, 1'b0, ERR_NONE);
                end
            end
            CMD_WRITE_LOCK: begin
                if (!lock_busy && reader_cnt == 0) begin
                    lock_busy = 1'b1;
                    post_status(KIND_GRANTED, who, 1'b1, ERR_NONE);
                end else if (wait_fill >= QUEUE_DEPTH) begin
                    post_status(KIND_ERROR, who, wr, ERR_QUEUE_FULL);
                end else begin
                    lock_busy = 1'b1;
                    enqueue_waiter(who, 1'b1);
                    post_status(KIND_QUEUED, who, 1'b1, ERR_NONE);
                end
            end
            CMD_READ_UNLOCK: begin
                if (reader_cnt == 0) begin
                    post_status(KIND_ERROR, who, wr, ERR_NO_HOLDER);
                end else begin
                    reader_cnt--;
                    if (reader_cnt == 0 && wait_fill > 0) begin
                        wake_waiters();
                    end else begin
                        post_status(KIND_RELEASED, who, 1'b0, ERR_NONE);
                    end
                end
            end
            default: begin
                if (!lock_busy || reader_cnt > 0) begin
                    post_status(KIND_ERROR, who, wr, ERR_NO_HOLDER);
                end else if (wait_fill == 0) begin
                    lock_busy = 1'b0;
                    post_status(KIND_RELEASED, who, 1'b1, ERR_NONE);
                end else begin
                    wake_waiters();
                end
            end
        endcase
        tail      = status_q.pop_back();
        tail.last = 1'b1;
        status_q.push_back(tail);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            lock_busy  = 1'b0;
            reader_cnt = '0;
            wait_head  = 0;
            wait_fill  = 0;
            status_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (status_q.size() == 0) begin
                    report_mismatch($sformatf("word %h kind %0d with none expected",
                                              i_m_tdata, i_m_tuser));
                end else begin
                    want = status_q.pop_front();
                    if (i_m_tuser != want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d",
                                                  i_m_tuser, want.kind));
                    if (i_m_tdata[5:0] != want.client)
                        report_mismatch($sformatf("client %0d, want %0d",
                                                  i_m_tdata[5:0], want.client));
                    if (i_m_tdata[6] != want.as_writer)
                        report_mismatch($sformatf("as_writer %0d, want %0d",
                                                  i_m_tdata[6], want.as_writer));
                    if (i_m_tdata[8:7] != want.error_code)
                        report_mismatch($sformatf("error_code %0d, want %0d",
                                                  i_m_tdata[8:7], want.error_code));
                    if (i_m_tdata[15:9] != want.active_readers)
                        report_mismatch($sformatf("active_readers %0d, want %0d",
                                                  i_m_tdata[15:9], want.active_readers));
                    if (i_m_tlast != want.last)
                        report_mismatch($sformatf("last %0d, want %0d",
                                                  i_m_tlast, want.last));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_request(t_cmd'(i_s_tuser), i_s_tdata[CLIENT_W-1:0]);
            end
        end
        o_pending <= status_q.size();
    end

endmodule

// ===== bench/fair_reader_writer_lock_tb.sv =====
// Top of the lock manager testbench: clock, reset, request stimulus and output stalls.
// Instantiates fair_reader_writer_lock and frwl_status_checker; uses frwl_pkg.
// The checker's mismatch count and the idle watchdog decide the verdict.
module fair_reader_writer_lock_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import frwl_pkg::*;

    localparam int RANDOM_ITEMS = 460;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_valid   = 1'b0;
    logic [S_DATA_W-1:0] s_data    = '0;
    logic [CMD_W-1:0]    s_cmd     = CMD_READ_LOCK;
    logic                s_ready;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [M_DATA_W-1:0] m_data;
    logic [1:0]          m_kind;
    logic                m_last;

    int mismatches;
    int pending_words;
    int sent_items  = 0;
    bit sender_calm = 1'b0;
    int rx_stall    = 0;
    int rx_run      = 0;
    int rx_pick;

    always #10 clk = ~clk;

    fair_reader_writer_lock u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_cmd),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_kind),
        .o_m_axis_tlast  (m_last)
    );

    frwl_status_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_cmd),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tuser    (m_kind),
        .i_m_tlast    (m_last),
        .o_mismatches (mismatches),
        .o_pending    (pending_words)
    );

    always @(posedge clk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else if (rx_run > 0) begin
            rx_run--;
            m_ready <= 1'b1;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 50) begin
                rx_run = $urandom_range(4, 40);
                m_ready <= 1'b1;
            end else if (rx_pick < 90) begin
                rx_stall = $urandom_range(1, 3);
                m_ready <= 1'b0;
            end else begin
                rx_stall = $urandom_range(10, 40);
                m_ready <= 1'b0;
            end
        end
    end

    task automatic issue_request(t_cmd cmd, logic [CLIENT_W-1:0] who);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (sender_calm || pick < 60) begin
            gap = 0;
        end else if (pick < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(S_DATA_W-CLIENT_W){1'b0}}, who};
        s_cmd   <= cmd;
        do @(negedge clk); while (!s_ready);
        @(posedge clk);
        sent_items++;
    endtask

    task automatic send_noise();
        issue_request(t_cmd'($urandom_range(0, 3)), CLIENT_W'($urandom_range(0, 63)));
    endtask

    task automatic send_mostly(t_cmd cmd);
        if ($urandom_range(0, 99) < 8) begin
            send_noise();
        end else begin
            issue_request(cmd, CLIENT_W'($urandom_range(0, 63)));
        end
    endtask

    // Readers hold the lock, a writer waits behind any of them, more readers and at times
    // a second writer queue behind it, then all release in the order that hands it along.
    task automatic run_episode();
        int  n_first;
        int  n_after;
        bit  second_writer;
        n_first       = $urandom_range(0, 4);
        n_after       = $urandom_range(0, 5);
        second_writer = ($urandom_range(0, 2) == 0);
        repeat (n_first) send_mostly(CMD_READ_LOCK);
        send_mostly(CMD_WRITE_LOCK);
        repeat (n_after) send_mostly(CMD_READ_LOCK);
        if (second_writer) send_mostly(CMD_WRITE_LOCK);
        repeat (n_first) send_mostly(CMD_READ_UNLOCK);
        send_mostly(CMD_WRITE_UNLOCK);
        repeat (n_after) send_mostly(CMD_READ_UNLOCK);
        if (second_writer) send_mostly(CMD_WRITE_UNLOCK);
    endtask

    initial begin : stimulus
        int n_flood;
        int goal;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_request(CMD_READ_UNLOCK, 6'd0);
        issue_request(CMD_WRITE_UNLOCK, 6'd63);
        issue_request(CMD_READ_LOCK, 6'd1);
        issue_request(CMD_WRITE_UNLOCK, 6'd2);
        issue_request(CMD_WRITE_LOCK, 6'd3);
        issue_request(CMD_READ_LOCK, 6'd4);
        issue_request(CMD_READ_UNLOCK, 6'd1);
        issue_request(CMD_WRITE_UNLOCK, 6'd3);
        issue_request(CMD_READ_UNLOCK, 6'd4);
        issue_request(CMD_WRITE_LOCK, 6'd63);
        issue_request(CMD_WRITE_UNLOCK, 6'd63);
        issue_request(CMD_WRITE_LOCK, 6'd62);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            issue_request(CMD_READ_LOCK, CLIENT_W'(i == 0 ? 0 : 47 + i));
        end
        issue_request(CMD_READ_LOCK, 6'd42);
        issue_request(CMD_WRITE_LOCK, 6'd43);
        issue_request(CMD_WRITE_UNLOCK, 6'd62);

        goal = RANDOM_ITEMS;

        // Sixteen readers hold the lock now; pile on more until the count saturates.
        n_flood = $urandom_range(50, 56);
        repeat (n_flood) issue_request(CMD_READ_LOCK, CLIENT_W'($urandom_range(0, 63)));
        repeat (n_flood + 18) issue_request(CMD_READ_UNLOCK, CLIENT_W'($urandom_range(0, 63)));

        while (sent_items < goal) begin
            sender_calm = ($urandom_range(0, 9) < 3);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) send_noise();
            end else begin
                run_episode();
            end
        end
        s_valid <= 1'b0;

        @(posedge clk);
        wait (pending_words == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("fair_reader_writer_lock_tb: done, clean");
        end else begin
            $display("fair_reader_writer_lock_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t ns: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("fair_reader_writer_lock_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/frwl_pkg.sv
rtl/frwl_front.sv
rtl/frwl_req_queue.sv
rtl/frwl_engine.sv
rtl/fair_reader_writer_lock.sv
rtl/frwl_checker.sv
bench/frwl_status_checker.sv
bench/fair_reader_writer_lock_tb.sv
